### rtl/core/arct_pkg.sv
// Shared types, constants and codes of the address range coalescing table.
package arct_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam int BASE_W    = 48;
    localparam int SIZE_W    = 32;
    localparam int END_W     = 49;
    localparam int IDX_W     = 4;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_COMPACT,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic walk_clr;
        logic walk_en;
        logic walk_compact;
        logic rd_issue;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_done;
        logic multi_hit;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/core/arct_in_if.sv
// Request channel: valid/ready handshake with insert or read payload.
interface arct_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [arct_pkg::BASE_W-1:0]    range_base;
    logic [arct_pkg::SIZE_W-1:0]    range_size;
    logic [arct_pkg::IDX_W-1:0]     entry_index;

    modport source (output valid, output operation, output range_base, output range_size,
                    output entry_index, input ready);
    modport sink   (input valid, input operation, input range_base, input range_size,
                    input entry_index, output ready);
endinterface

### rtl/core/arct_out_if.sv
// Response channel: valid/ready handshake with status, count and range payload.
interface arct_out_if;
    logic                           valid;
    logic                           ready;
    logic [arct_pkg::STAT_W-1:0]    status;
    logic [arct_pkg::CNT_OUT_W-1:0] entry_count;
    logic [arct_pkg::BASE_W-1:0]    entry_begin_out;
    logic [arct_pkg::END_W-1:0]     entry_end_out;

    modport source (output valid, output status, output entry_count, output entry_begin_out,
                    output entry_end_out, input ready);
    modport sink   (input valid, input status, input entry_count, input entry_begin_out,
                    input entry_end_out, output ready);
endinterface

### rtl/core/arct_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module arct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### rtl/core/arct_ctrl.sv
// Sequencer: read or scan, optional compaction, then commit per item.
module arct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_operation,
    input  arct_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output arct_pkg::t_dp_cmd o_cmd
);
    arct_pkg::t_state r_state;
    arct_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arct_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            arct_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_operation == arct_pkg::OP_READ) ? arct_pkg::S_RD
                                                                  : arct_pkg::S_SCAN;
                end
            end
            arct_pkg::S_RD: begin
                n_state = arct_pkg::S_COMMIT;
            end
            arct_pkg::S_SCAN: begin
                if (i_sts.walk_done) begin
                    n_state = i_sts.multi_hit ? arct_pkg::S_COMPACT : arct_pkg::S_COMMIT;
                end
            end
            arct_pkg::S_COMPACT: begin
                if (i_sts.walk_done) begin
                    n_state = arct_pkg::S_COMMIT;
                end
            end
            arct_pkg::S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = arct_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = arct_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            arct_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            arct_pkg::S_RD: begin
                o_cmd.rd_issue = 1'b1;
            end
            arct_pkg::S_SCAN: begin
                // rewind the walk for the compaction pass
                o_cmd.walk_en  = !i_sts.walk_done;
                o_cmd.walk_clr = i_sts.walk_done && i_sts.multi_hit;
            end
            arct_pkg::S_COMPACT: begin
                o_cmd.walk_en      = !i_sts.walk_done;
                o_cmd.walk_compact = 1'b1;
            end
            arct_pkg::S_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

### rtl/core/arct_dp.sv
// Datapath: range store, overlap walk, union accumulation and result register.
module arct_dp #(
    parameter int TABLE_DEPTH = arct_pkg::DEF_TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  arct_pkg::t_dp_cmd                 i_cmd,
    output arct_pkg::t_dp_sts                 o_sts,
    input  logic                              i_operation,
    input  logic [arct_pkg::BASE_W-1:0]       i_range_base,
    input  logic [arct_pkg::SIZE_W-1:0]       i_range_size,
    input  logic [arct_pkg::IDX_W-1:0]        i_entry_index,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [arct_pkg::STAT_W-1:0]       o_status,
    output logic [arct_pkg::CNT_OUT_W-1:0]    o_entry_count,
    output logic [arct_pkg::BASE_W-1:0]       o_entry_begin_out,
    output logic [arct_pkg::END_W-1:0]        o_entry_end_out
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int BW = arct_pkg::BASE_W;
    localparam int EW = arct_pkg::END_W;
    localparam int XW = arct_pkg::IDX_W;
    localparam int OW = arct_pkg::CNT_OUT_W;
    localparam int RW = BW + EW;

    // captured item
    logic          r_op;
    logic [BW-1:0] r_nb;
    logic [EW-1:0] r_ne;
    logic [XW-1:0] r_idx;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // walk over the store
    logic [CW-1:0] r_addr;
    logic          r_pend;
    logic [IW-1:0] r_pend_addr;
    logic [CW-1:0] r_kept;
    logic [1:0]    r_hits;
    logic [IW-1:0] r_first;
    logic [BW-1:0] r_ub;
    logic [EW-1:0] r_ue;

    // result register
    logic              r_out_valid;
    logic              n_out_valid;
    arct_pkg::t_status r_out_status;
    arct_pkg::t_status n_out_status;
    logic [OW-1:0]     r_out_cnt;
    logic [BW-1:0]     r_out_b;
    logic [BW-1:0]     n_out_b;
    logic [EW-1:0]     r_out_e;
    logic [EW-1:0]     n_out_e;

    logic          w_clr;
    logic          w_issue;
    logic          w_rd_en;
    logic [IW-1:0] w_rd_addr;
    logic [RW-1:0] w_rd_data;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    logic [RW-1:0] w_wr_data;
    logic [BW-1:0] w_st_lo;
    logic [EW-1:0] w_st_hi;
    logic          w_ovl;
    logic          w_scan_hit;
    logic          w_keep;
    logic          w_full;
    logic          w_in_range;
    logic [EW-1:0] w_ne_in;
    logic [CW+XW-1:0] w_idx_x;
    logic [CW+XW-1:0] w_cnt_x;
    logic [IW+XW-1:0] w_idx_addr_x;
    logic [CW+OW-1:0] w_ncnt_x;

    assign w_clr   = i_cmd.walk_clr || i_cmd.load;
    assign w_issue = i_cmd.walk_en && !w_clr && (r_addr != r_count);
    assign w_ne_in = {1'b0, i_range_base} + {{(EW - arct_pkg::SIZE_W){1'b0}}, i_range_size};

    assign w_idx_addr_x = {{IW{1'b0}}, r_idx};
    assign w_idx_x      = {{CW{1'b0}}, r_idx};
    assign w_cnt_x      = {{XW{1'b0}}, r_count};
    assign w_in_range   = w_idx_x < w_cnt_x;
    assign w_full       = r_count == CW'(TABLE_DEPTH);

    assign w_rd_en   = w_issue || i_cmd.rd_issue;
    assign w_rd_addr = i_cmd.rd_issue ? w_idx_addr_x[IW-1:0] : r_addr[IW-1:0];

    arct_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // entry word is {end, begin}
    assign w_st_lo = w_rd_data[BW-1:0];
    assign w_st_hi = w_rd_data[RW-1:BW];

    assign w_ovl = ((w_st_lo <= r_nb) && ({1'b0, r_nb} < w_st_hi)) ||
                   ((r_nb <= w_st_lo) && ({1'b0, w_st_lo} < r_ne));

    assign w_scan_hit = r_pend && w_ovl && !i_cmd.walk_compact;
    assign w_keep     = r_pend && !w_ovl && i_cmd.walk_compact;

    always_comb begin
        w_wr_en      = w_keep;
        w_wr_addr    = r_kept[IW-1:0];
        w_wr_data    = w_rd_data;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = arct_pkg::ST_OK;
        n_out_b      = r_ub;
        n_out_e      = r_ue;
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
            w_wr_data   = {r_ue, r_ub};
            if (r_op == arct_pkg::OP_READ) begin
                w_wr_en = 1'b0;
                if (w_in_range) begin
                    n_out_b = w_st_lo;
                    n_out_e = w_st_hi;
                end else begin
                    n_out_status = arct_pkg::ST_RANGE;
                    n_out_b      = '0;
                    n_out_e      = '0;
                end
            end else if (r_hits == 2'd0) begin
                if (w_full) begin
                    w_wr_en      = 1'b0;
                    n_out_status = arct_pkg::ST_FULL;
                    n_out_b      = '0;
                    n_out_e      = '0;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_count[IW-1:0];
                    n_count   = r_count + 1'b1;
                end
            end else if (r_hits == 2'd1) begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_first;
            end else begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_kept[IW-1:0];
                n_count   = r_kept + 1'b1;
            end
        end
    end

    assign w_ncnt_x = {{OW{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= w_clr ? 1'b0 : w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_nb   <= i_range_base;
            r_ne   <= w_ne_in;
            r_idx  <= i_entry_index;
            r_hits <= 2'd0;
            r_ub   <= i_range_base;
            r_ue   <= w_ne_in;
        end else if (w_scan_hit) begin
            if (r_hits == 2'd0) begin
                r_first <= r_pend_addr;
            end
            if (r_hits != 2'd2) begin
                r_hits <= r_hits + 2'd1;
            end
            if (w_st_lo < r_ub) begin
                r_ub <= w_st_lo;
            end
            if (w_st_hi > r_ue) begin
                r_ue <= w_st_hi;
            end
        end

        if (w_clr) begin
            r_addr <= '0;
            r_kept <= '0;
        end else begin
            if (w_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (w_keep) begin
                r_kept <= r_kept + 1'b1;
            end
        end
        if (w_issue) begin
            r_pend_addr <= r_addr[IW-1:0];
        end

        if (i_cmd.commit) begin
            r_out_status <= n_out_status;
            r_out_cnt    <= w_ncnt_x[OW-1:0];
            r_out_b      <= n_out_b;
            r_out_e      <= n_out_e;
        end
    end

    assign o_sts.walk_done = (r_addr == r_count) && !r_pend;
    assign o_sts.multi_hit = r_hits == 2'd2;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_entry_count     = r_out_cnt;
    assign o_entry_begin_out = r_out_b;
    assign o_entry_end_out   = r_out_e;
endmodule

### rtl/core/address_range_coalescing_table.sv
// Top level of the address range coalescing table.
//
// Holds up to TABLE_DEPTH half-open ranges [begin, end) in a single-port-read
// RAM. An insert transfer (base, size) walks the stored entries one per cycle
// and tests each for overlap with the new range, counting hits and building the
// union as it goes. No hit: the range is appended, or refused with the full
// status when the table is full. One hit: that entry is widened in place. Two
// or more hits: a second walk packs the untouched entries to the front in order
// and the union lands after them. Adjacent ranges are not merged, and a widened
// entry is not merged with its neighbours until a later insert covers them.
// A read transfer returns the entry at entry_index, or the beyond-count status.
// Each walk issues a read for every stored entry, drains the last read and then
// sees the walk finished. The RAM read port serves one entry per cycle to the
// overlap walk. One item is in flight at a time; a finished result sits in an
// output register so the next request transfer is taken while it waits, and
// that item's commit holds until the register is free. The store needs no
// clearing after reset: only entries below the count are used.
module address_range_coalescing_table #(
    parameter int TABLE_DEPTH = arct_pkg::DEF_TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    arct_in_if.sink      i_req,
    arct_out_if.source   o_rsp
);
    arct_pkg::t_dp_cmd w_cmd;
    arct_pkg::t_dp_sts w_sts;
    logic              w_in_ready;

    // sequencer
    arct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_operation (i_req.operation),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd)
    );

    // store, overlap walk and result register
    arct_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_operation       (i_req.operation),
        .i_range_base      (i_req.range_base),
        .i_range_size      (i_req.range_size),
        .i_entry_index     (i_req.entry_index),
        .i_out_ready       (o_rsp.ready),
        .o_out_valid       (o_rsp.valid),
        .o_status          (o_rsp.status),
        .o_entry_count     (o_rsp.entry_count),
        .o_entry_begin_out (o_rsp.entry_begin_out),
        .o_entry_end_out   (o_rsp.entry_end_out)
    );

    assign i_req.ready = w_in_ready;
endmodule

### tb/tb_address_range_coalescing_table.sv
// Self-checking testbench for the address range coalescing table: directed cases, then random traffic.
module tb_address_range_coalescing_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = arct_pkg::DEF_TABLE_DEPTH;
    localparam int MAX_REPORTS = 10;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 100;
    localparam logic [arct_pkg::SIZE_W-1:0] SIZE_MAX = '1;
    localparam logic [arct_pkg::BASE_W-1:0] BASE_MAX = '1;

    // One reply as the table should give it.
    typedef struct packed {
        arct_pkg::t_status              status;
        logic [arct_pkg::CNT_OUT_W-1:0] count;
        logic [arct_pkg::BASE_W-1:0]    rbegin;
        logic [arct_pkg::END_W-1:0]     rend;
    } t_range_reply;

    logic clk = 1'b0;
    logic rst_n;

    // Clock: 20 ns period.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    arct_in_if  req_bus ();
    arct_out_if rsp_bus ();

    address_range_coalescing_table #(
        .TABLE_DEPTH (DEPTH)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Our own copy of the range store, kept in step with accepted transfers.
    logic [arct_pkg::BASE_W-1:0] held_begin [DEPTH];
    logic [arct_pkg::END_W-1:0]  held_end   [DEPTH];
    int                          held_count;

    // Replies still owed by the block, oldest first.
    t_range_reply      due_replies [$];
    t_range_reply      want;

    // Idling on both sides of the block is switched per phase.
    bit idle_on;

    int fail_count;
    int n_sent, n_append, n_widen, n_union, n_full, n_read_ok, n_read_range;

    // Half-open overlap test, both ways round; begins are carried at end width.
    function automatic logic spans_meet(input logic [arct_pkg::END_W-1:0] ab,
                                        input logic [arct_pkg::END_W-1:0] ae,
                                        input logic [arct_pkg::END_W-1:0] bb,
                                        input logic [arct_pkg::END_W-1:0] be);
        return (ab <= bb && bb < ae) || (bb <= ab && ab < be);
    endfunction

    // Applies one request to the held ranges and returns the reply it must produce.
    function automatic t_range_reply apply_to_ranges(input logic op,
                                                     input logic [arct_pkg::BASE_W-1:0] base,
                                                     input logic [arct_pkg::SIZE_W-1:0] size,
                                                     input logic [arct_pkg::IDX_W-1:0] idx);
        t_range_reply                r;
        logic [arct_pkg::END_W-1:0]  nb, ne, ub, ue;
        int                          hits, first_hit, kept, i;

        r         = '0;
        hits      = 0;
        first_hit = 0;
        kept      = 0;

        if (op == arct_pkg::OP_READ) begin
            // An index at or past the count reads nothing and flags it.
            if (int'(idx) >= held_count) begin
                r.status = arct_pkg::ST_RANGE;
                n_read_range++;
            end else begin
                r.status = arct_pkg::ST_OK;
                r.rbegin = held_begin[idx];
                r.rend   = held_end[idx];
                n_read_ok++;
            end
            r.count = arct_pkg::CNT_OUT_W'(held_count);
            return r;
        end

        nb = {1'b0, base};
        ne = nb + arct_pkg::END_W'(size);

        for (i = 0; i < held_count; i++) begin
            if (spans_meet({1'b0, held_begin[i]}, held_end[i], nb, ne)) begin
                if (hits == 0)
                    first_hit = i;
                hits++;
            end
        end

        if (hits == 0) begin
            if (held_count >= DEPTH) begin
                // Nowhere to put it: dropped, nothing changes.
                r.status = arct_pkg::ST_FULL;
                n_full++;
            end else begin
                held_begin[held_count] = base;
                held_end[held_count]   = ne;
                held_count++;
                r.status = arct_pkg::ST_OK;
                r.rbegin = base;
                r.rend   = ne;
                n_append++;
            end
        end else if (hits == 1) begin
            // Widen the one entry in place; no cascade into its neighbours.
            ub = ({1'b0, held_begin[first_hit]} < nb) ? {1'b0, held_begin[first_hit]} : nb;
            ue = (held_end[first_hit] > ne) ? held_end[first_hit] : ne;
            held_begin[first_hit] = ub[arct_pkg::BASE_W-1:0];
            held_end[first_hit]   = ue;
            r.status = arct_pkg::ST_OK;
            r.rbegin = ub[arct_pkg::BASE_W-1:0];
            r.rend   = ue;
            n_widen++;
        end else begin
            // Several hits: pack the others to the front in order, union goes last.
            ub = nb;
            ue = ne;
            for (i = 0; i < held_count; i++) begin
                if (spans_meet({1'b0, held_begin[i]}, held_end[i], nb, ne)) begin
                    if ({1'b0, held_begin[i]} < ub)
                        ub = {1'b0, held_begin[i]};
                    if (held_end[i] > ue)
                        ue = held_end[i];
                end else begin
                    held_begin[kept] = held_begin[i];
                    held_end[kept]   = held_end[i];
                    kept++;
                end
            end
            held_begin[kept] = ub[arct_pkg::BASE_W-1:0];
            held_end[kept]   = ue;
            held_count       = kept + 1;
            r.status = arct_pkg::ST_OK;
            r.rbegin = ub[arct_pkg::BASE_W-1:0];
            r.rend   = ue;
            n_union++;
        end
        r.count = arct_pkg::CNT_OUT_W'(held_count);
        return r;
    endfunction

    // Presents one request and holds it until the transfer happens. The expected
    // reply is worked out at the edge where the request is taken.
    task automatic send_item(input logic op, input logic [arct_pkg::BASE_W-1:0] base,
                             input logic [arct_pkg::SIZE_W-1:0] size,
                             input logic [arct_pkg::IDX_W-1:0] idx);
        int           gap;
        t_range_reply owed;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0) begin
            @(negedge clk);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_bus.valid       <= 1'b1;
        req_bus.operation   <= op;
        req_bus.range_base  <= base;
        req_bus.range_size  <= size;
        req_bus.entry_index <= idx;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        owed        = apply_to_ranges(op, base, size, idx);
        due_replies = {due_replies, owed};
        n_sent++;
    endtask

    // Stops sending and waits for every owed reply to arrive.
    task automatic wait_for_replies();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge clk);
    endtask

    // Small hand-picked sequence near address zero: appends, adjacency, widening,
    // empty ranges, a multi-entry union, reads in and out of range, top-end values.
    task automatic test_directed_cases();
        idle_on = 1'b0;
        send_item(arct_pkg::OP_READ,   '0,      '0,     4'd0);   // empty store: beyond count
        send_item(arct_pkg::OP_INSERT, 48'd100, 32'd50, 4'd0);   // [100,150) appended
        send_item(arct_pkg::OP_INSERT, 48'd150, 32'd10, 4'd0);   // adjacent, kept apart
        send_item(arct_pkg::OP_INSERT, 48'd120, 32'd10, 4'd0);   // inside one entry
        send_item(arct_pkg::OP_INSERT, 48'd90,  32'd20, 4'd0);   // widens it downwards
        send_item(arct_pkg::OP_INSERT, 48'd200, 32'd0,  4'd0);   // empty range stored as is
        send_item(arct_pkg::OP_INSERT, 48'd200, 32'd5,  4'd0);   // meets the empty one
        send_item(arct_pkg::OP_INSERT, 48'd300, 32'd0,  4'd0);
        send_item(arct_pkg::OP_INSERT, 48'd300, 32'd0,  4'd0);   // two empty ranges never meet
        send_item(arct_pkg::OP_INSERT, 48'd140, 32'd70, 4'd0);   // hits three: union, compaction
        send_item(arct_pkg::OP_INSERT, 48'd220, 32'd10, 4'd0);
        send_item(arct_pkg::OP_INSERT, 48'd208, 32'd12, 4'd0);   // widened entry touches next
        send_item(arct_pkg::OP_READ,   '0,      '0,     4'd2);
        send_item(arct_pkg::OP_READ,   '0,      '0,     4'd3);
        send_item(arct_pkg::OP_INSERT, 48'd219, 32'd2,  4'd0);   // later insert joins them
        send_item(arct_pkg::OP_INSERT, BASE_MAX, SIZE_MAX, 4'd15);
        send_item(arct_pkg::OP_READ,   '0,      '0,     4'd3);
        send_item(arct_pkg::OP_READ,   '0,      '0,     4'd15);
        // index equal to count
        send_item(arct_pkg::OP_READ,   '0,      '0,     arct_pkg::IDX_W'(held_count));
        wait_for_replies();
    endtask

    // Fills every slot, checks the refusal, then shows overlapping inserts still
    // go in at full and a wide sweep collapses the low region.
    task automatic test_table_full();
        int k;
        idle_on = 1'b1;
        k = 0;
        while (held_count < DEPTH) begin
            send_item(arct_pkg::OP_INSERT, 48'h1_0000 + arct_pkg::BASE_W'(k) * 48'h100,
                      32'h10, arct_pkg::IDX_W'(k));
            k++;
        end
        send_item(arct_pkg::OP_INSERT, 48'h2_0000, 32'h8, 4'd0);
        send_item(arct_pkg::OP_INSERT, 48'h1_0508, 32'h20, 4'd0);
        send_item(arct_pkg::OP_READ,   '0, '0, 4'd15);
        send_item(arct_pkg::OP_INSERT, '0, SIZE_MAX, 4'd0);
        send_item(arct_pkg::OP_READ,   '0, '0, 4'd0);
        send_item(arct_pkg::OP_READ,   '0, '0, 4'd1);
        wait_for_replies();
    endtask

    // Phases of random traffic, each in its own 8 GiB region so that the region
    // can be swept into one entry at the end and slots free up again. Within a
    // phase most inserts land in a 4 KiB window to get plenty of overlaps.
    task automatic test_random_traffic();
        logic [arct_pkg::BASE_W-1:0] group_base;
        logic [arct_pkg::IDX_W-1:0]  idx;
        int                          phase, n, roll;
        for (phase = 0; phase < N_PHASES; phase++) begin
            group_base = {15'($urandom_range(1, 32767)), 33'd0};
            // No idling at all in the closing phases.
            idle_on = (phase < N_PHASES - 2) && ($urandom_range(0, 2) != 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                idx  = arct_pkg::IDX_W'($urandom_range(0, 15));
                if (roll < 25) begin
                    if (held_count > 0 && $urandom_range(0, 1) == 1)
                        idx = arct_pkg::IDX_W'($urandom_range(0, held_count - 1));
                    send_item(arct_pkg::OP_READ, arct_pkg::BASE_W'($urandom()),
                              arct_pkg::SIZE_W'($urandom()), idx);
                end else if (roll < 32) begin
                    send_item(arct_pkg::OP_INSERT,
                              group_base + arct_pkg::BASE_W'($urandom_range(0, 32'h8000_0000)),
                              arct_pkg::SIZE_W'($urandom()), idx);
                end else if (roll < 40) begin
                    send_item(arct_pkg::OP_INSERT,
                              group_base + arct_pkg::BASE_W'($urandom_range(0, 4095)),
                              arct_pkg::SIZE_W'($urandom_range(500, 3000)), idx);
                end else if (roll < 45) begin
                    send_item(arct_pkg::OP_INSERT,
                              group_base + arct_pkg::BASE_W'($urandom_range(0, 4095)), '0, idx);
                end else begin
                    send_item(arct_pkg::OP_INSERT,
                              group_base + arct_pkg::BASE_W'($urandom_range(0, 4095)),
                              arct_pkg::SIZE_W'($urandom_range(1, 300)), idx);
                end
            end
            send_item(arct_pkg::OP_INSERT, group_base,
                      SIZE_MAX - arct_pkg::SIZE_W'($urandom_range(0, 255)), '0);
            // Sender holds off here until the block has answered everything.
            wait_for_replies();
        end
    endtask

    // Reply side: ready drops in random bursts while idling is on.
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!rst_n) begin
                rsp_bus.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge clk);
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Each reply transfer is compared with the oldest owed reply.
    always @(posedge clk) begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (due_replies.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: reply with none owed: status %0d count %0d begin %h end %h",
                             $realtime, rsp_bus.status, rsp_bus.entry_count,
                             rsp_bus.entry_begin_out, rsp_bus.entry_end_out);
            end else begin
                want = due_replies.pop_front();
                if (rsp_bus.status !== want.status || rsp_bus.entry_count !== want.count ||
                    rsp_bus.entry_begin_out !== want.rbegin ||
                    rsp_bus.entry_end_out !== want.rend) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"%0t: reply mismatch (expected/actual): status %0d/%0d",
                                  " count %0d/%0d begin %h/%h end %h/%h"},
                                 $realtime, want.status, rsp_bus.status,
                                 want.count, rsp_bus.entry_count,
                                 want.rbegin, rsp_bus.entry_begin_out,
                                 want.rend, rsp_bus.entry_end_out);
                end
            end
        end
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.operation   = arct_pkg::OP_INSERT;
        req_bus.range_base  = '0;
        req_bus.range_size  = '0;
        req_bus.entry_index = '0;
        idle_on             = 1'b0;
        held_count          = 0;
        fail_count          = 0;
        for (int i = 0; i < DEPTH; i++) begin
            held_begin[i] = '0;
            held_end[i]   = '0;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_table_full();
        test_random_traffic();

        // After the last owed reply, wait on for any stray replies.
        wait_for_replies();
        repeat (2 * DEPTH + 8) @(posedge clk);
        fail_count += due_replies.size();

        $display("Sent %0d requests: %0d appended, %0d widened, %0d unions, %0d refused full.",
                 n_sent, n_append, n_widen, n_union, n_full);
        $display("Reads: %0d returned an entry, %0d past the count; %0d bad replies.",
                 n_read_ok, n_read_range, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/arct_pkg.sv
rtl/core/arct_in_if.sv
rtl/core/arct_out_if.sv
rtl/core/arct_ram.sv
rtl/core/arct_ctrl.sv
rtl/core/arct_dp.sv
rtl/core/address_range_coalescing_table.sv
tb/tb_address_range_coalescing_table.sv
